@@ src/ilid_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants for the indexed list with insert and delete.
// ---------------------------------------------------------------------------
package ilid_pkg;

    localparam int DEPTH  = 64;
    localparam int VAL_W  = 31;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
    localparam int GRP    = 8;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

    typedef enum logic [2:0] {
        CMD_GET      = 3'd0,
        CMD_ADD_HEAD = 3'd1,
        CMD_ADD_TAIL = 3'd2,
        CMD_ADD_IDX  = 3'd3,
        CMD_DEL_IDX  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ src/ilid_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilid_cell
// One list slot: holds an entry, takes its left neighbor on insert, the new
// value at the insert position, or its right neighbor on delete.
// ---------------------------------------------------------------------------
module ilid_cell (
    input  logic                          i_clk,
    input  ilid_pkg::t_cell_ctl           i_ctl,
    input  logic [ilid_pkg::IDX_W-1:0]    i_idx,
    input  logic [ilid_pkg::VAL_W-1:0]    i_left,
    input  logic [ilid_pkg::VAL_W-1:0]    i_right,
    output logic [ilid_pkg::VAL_W-1:0]    o_q,
    output logic [ilid_pkg::VAL_W-1:0]    o_rd
);

    logic [ilid_pkg::VAL_W-1:0] r_q;
    logic [ilid_pkg::VAL_W-1:0] n_q;
    logic [ilid_pkg::CMP_W-1:0] idx_ext;

    assign idx_ext = ilid_pkg::CMP_W'(i_idx);

    always_comb begin
        n_q = r_q;
        if (i_ctl.ins) begin
            if (idx_ext > i_ctl.pos) begin
                n_q = i_left;
            end else if (idx_ext == i_ctl.pos) begin
                n_q = i_ctl.value;
            end
        end else if (i_ctl.del && (idx_ext >= i_ctl.pos)) begin
            n_q = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q  = r_q;
    assign o_rd = (idx_ext == i_ctl.pos) ? r_q : '0;

endmodule

@@ src/ilid_rdor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilid_rdor
// Read combine: registers the OR of each group of gated cell outputs, then
// merges the group results.
// ---------------------------------------------------------------------------
module ilid_rdor (
    input  logic                          i_clk,
    input  logic [ilid_pkg::VAL_W-1:0]    i_rd [ilid_pkg::DEPTH],
    output logic [ilid_pkg::VAL_W-1:0]    o_val
);

    logic [ilid_pkg::VAL_W-1:0] r_grp [ilid_pkg::NGRP];
    logic [ilid_pkg::VAL_W-1:0] n_grp [ilid_pkg::NGRP];

    always_comb begin
        for (int g = 0; g < ilid_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < ilid_pkg::GRP; k++) begin
                if (g * ilid_pkg::GRP + k < ilid_pkg::DEPTH) begin
                    n_grp[g] = n_grp[g] | i_rd[g * ilid_pkg::GRP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    always_comb begin
        o_val = '0;
        for (int g = 0; g < ilid_pkg::NGRP; g++) begin
            o_val = o_val | r_grp[g];
        end
    end

endmodule

@@ src/indexed_list_insert_delete.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to DEPTH values held in a row of shifting cells.
// Result strobe: accept is registered in r_s1_vld and then in r_strobe.
// A new transaction is not accepted while busy; busy covers the read combine.
// Cells at and beyond the position shift in the accepting cycle; the get path goes
// through a registered OR tree over the cells.
// Reset: synchronous, clears the length and the pipeline; entries are not
// cleared. The receiver cannot stall results.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_cmd,
    input  logic [ilid_pkg::POS_W-1:0]    i_position,
    input  logic [ilid_pkg::VAL_W-1:0]    i_value,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [ilid_pkg::VAL_W-1:0]    o_read_value,
    output logic [ilid_pkg::LEN_W-1:0]    o_list_length
);

    logic                          accept;
    logic [ilid_pkg::CMP_W-1:0]    pos_ext;
    logic [ilid_pkg::CMP_W-1:0]    cnt_ext;
    logic [ilid_pkg::CMP_W-1:0]    ins_pos;
    logic                          is_ins;
    ilid_pkg::t_status             status;
    logic                          get_ok;
    ilid_pkg::t_cell_ctl           ctl;
    logic [ilid_pkg::VAL_W-1:0]    cell_q  [ilid_pkg::DEPTH];
    logic [ilid_pkg::VAL_W-1:0]    cell_rd [ilid_pkg::DEPTH];
    logic [ilid_pkg::VAL_W-1:0]    rd_val;

    logic [ilid_pkg::CNT_W-1:0]    r_count;
    logic [ilid_pkg::CNT_W-1:0]    n_count;
    logic                          r_s1_vld;
    ilid_pkg::t_status             r_s1_status;
    logic                          r_s1_get_ok;
    logic                          r_strobe;
    ilid_pkg::t_status             r_status;
    logic [ilid_pkg::VAL_W-1:0]    r_read_value;

    assign accept  = start && !r_s1_vld;
    assign pos_ext = ilid_pkg::CMP_W'(i_position);
    assign cnt_ext = ilid_pkg::CMP_W'(r_count);

    always_comb begin
        ins_pos = pos_ext;
        is_ins  = 1'b0;
        get_ok  = 1'b0;
        status  = ilid_pkg::ST_RANGE;
        case (i_cmd)
            ilid_pkg::CMD_GET: begin
                get_ok = pos_ext < cnt_ext;
                status = get_ok ? ilid_pkg::ST_DONE : ilid_pkg::ST_RANGE;
            end
            ilid_pkg::CMD_ADD_HEAD: begin
                ins_pos = '0;
                is_ins  = 1'b1;
            end
            ilid_pkg::CMD_ADD_TAIL: begin
                ins_pos = cnt_ext;
                is_ins  = 1'b1;
            end
            ilid_pkg::CMD_ADD_IDX: begin
                is_ins = 1'b1;
            end
            ilid_pkg::CMD_DEL_IDX: begin
                status = (pos_ext < cnt_ext) ? ilid_pkg::ST_DONE : ilid_pkg::ST_RANGE;
            end
            default: begin
                status = ilid_pkg::ST_RANGE;
            end
        endcase
        if (is_ins) begin
            if (ins_pos > cnt_ext) begin
                status = ilid_pkg::ST_RANGE;
            end else if (cnt_ext == ilid_pkg::CMP_W'(ilid_pkg::DEPTH)) begin
                status = ilid_pkg::ST_FULL;
            end else begin
                status = ilid_pkg::ST_DONE;
            end
        end
    end

    always_comb begin
        ctl.ins   = accept && is_ins && (status == ilid_pkg::ST_DONE);
        ctl.del   = accept && (i_cmd == ilid_pkg::CMD_DEL_IDX) && (status == ilid_pkg::ST_DONE);
        ctl.pos   = ins_pos;
        ctl.value = i_value;
        n_count   = r_count;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctl.del) begin
            n_count = r_count - 1'b1;
        end
    end

    for (genvar g = 0; g < ilid_pkg::DEPTH; g++) begin : g_cell
        logic [ilid_pkg::VAL_W-1:0] w_left;
        logic [ilid_pkg::VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = cell_q[g-1];
        end
        if (g == ilid_pkg::DEPTH - 1) begin : g_last
            assign w_right = cell_q[g];
        end else begin : g_mid_r
            assign w_right = cell_q[g+1];
        end
        ilid_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_idx   (ilid_pkg::IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (cell_q[g]),
            .o_rd    (cell_rd[g])
        );
    end

    ilid_rdor u_rdor (
        .i_clk (i_clk),
        .i_rd  (cell_rd),
        .o_val (rd_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_s1_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_s1_vld <= accept;
            r_strobe <= r_s1_vld;
        end
        r_s1_status  <= status;
        r_s1_get_ok  <= get_ok;
        r_status     <= r_s1_status;
        r_read_value <= r_s1_get_ok ? rd_val : '0;
    end

    assign busy          = r_s1_vld;
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_list_length = ilid_pkg::LEN_W'(cnt_ext);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= ilid_pkg::CMP_W'(ilid_pkg::DEPTH))
        else $error("list length above depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_strobe)
        else $error("missing result strobe");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !accept)
        else $error("transaction accepted while busy");

    a_len_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && status != ilid_pkg::ST_DONE) |=> $stable(r_count))
        else $error("length changed on ignored transaction");

endmodule

@@ test/indexed_list_insert_delete_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_list_insert_delete_tb
// Self-checking testbench for the indexed list with insert and delete.
// A directed table covers the empty list, the edges of position and value,
// appending through add-at-index, out-of-range reads, inserts and deletes,
// and unused command codes. Random commands follow in grow and drain phases
// so that the list keeps filling up and emptying again. Every result is
// checked field by field against the table or a behavioral copy of the list.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete_tb;

    localparam int N_RANDOM   = 1350;
    localparam int QUIET_TAIL = 150;
    localparam int MAX_SHOWN  = 10;

    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    localparam logic [ilid_pkg::VAL_W-1:0] VAL_MAX = {ilid_pkg::VAL_W{1'b1}};
    localparam logic [ilid_pkg::POS_W-1:0] POS_MAX = {ilid_pkg::POS_W{1'b1}};

    typedef struct packed {
        ilid_pkg::t_status          status;
        logic [ilid_pkg::VAL_W-1:0] read_value;
        logic [ilid_pkg::LEN_W-1:0] list_length;
    } t_result;

    typedef struct packed {
        logic [2:0]                 cmd;
        logic [ilid_pkg::POS_W-1:0] pos;
        logic [ilid_pkg::VAL_W-1:0] val;
        bit                         typed;
        t_result                    res;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [2:0]                 i_cmd;
    logic [ilid_pkg::POS_W-1:0] i_position;
    logic [ilid_pkg::VAL_W-1:0] i_value;
    logic                       o_strobe;
    logic [1:0]                 o_status;
    logic [ilid_pkg::VAL_W-1:0] o_read_value;
    logic [ilid_pkg::LEN_W-1:0] o_list_length;

    logic [ilid_pkg::VAL_W-1:0] list_mem [ilid_pkg::DEPTH];
    int                         list_len;

    t_result pending_results [$];
    t_row    dir_rows [$];
    t_result got_res;

    int n_sent;
    int n_checked;
    int n_errors;
    int n_full;
    int n_ignored;
    int peak_len;

    always #5 i_clk = ~i_clk;

    indexed_list_insert_delete uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_list_length(o_list_length)
    );

    function automatic ilid_pkg::t_status list_insert(input int at,
                                                      input logic [ilid_pkg::VAL_W-1:0] val);
        if (at > list_len) return ilid_pkg::ST_RANGE;
        if (list_len >= ilid_pkg::DEPTH) return ilid_pkg::ST_FULL;
        for (int k = list_len; k > at; k--) list_mem[k] = list_mem[k-1];
        list_mem[at] = val;
        list_len++;
        return ilid_pkg::ST_DONE;
    endfunction

    function automatic t_result list_apply(input logic [2:0] cmd,
                                           input logic [ilid_pkg::POS_W-1:0] pos,
                                           input logic [ilid_pkg::VAL_W-1:0] val);
        t_result r;
        int      at;
        r.status     = ilid_pkg::ST_RANGE;
        r.read_value = '0;
        at           = int'(pos);
        case (cmd)
            ilid_pkg::CMD_GET: begin
                if (at < list_len) begin
                    r.read_value = list_mem[at];
                    r.status     = ilid_pkg::ST_DONE;
                end
            end
            ilid_pkg::CMD_ADD_HEAD: r.status = list_insert(0, val);
            ilid_pkg::CMD_ADD_TAIL: r.status = list_insert(list_len, val);
            ilid_pkg::CMD_ADD_IDX:  r.status = list_insert(at, val);
            ilid_pkg::CMD_DEL_IDX: begin
                if (at < list_len) begin
                    for (int k = at; k < list_len - 1; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                    r.status = ilid_pkg::ST_DONE;
                end
            end
            default: r.status = ilid_pkg::ST_RANGE;
        endcase
        r.list_length = ilid_pkg::LEN_W'(list_len);
        return r;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [ilid_pkg::POS_W-1:0] pos,
                           input logic [ilid_pkg::VAL_W-1:0] val, input bit typed,
                           input ilid_pkg::t_status st,
                           input logic [ilid_pkg::VAL_W-1:0] rd,
                           input logic [ilid_pkg::LEN_W-1:0] len);
        t_row row;
        row.cmd             = cmd;
        row.pos             = pos;
        row.val             = val;
        row.typed           = typed;
        row.res.status      = st;
        row.res.read_value  = rd;
        row.res.list_length = len;
        dir_rows = {dir_rows, row};
    endtask

    task automatic issue_cmd(input logic [2:0] cmd, input logic [ilid_pkg::POS_W-1:0] pos,
                             input logic [ilid_pkg::VAL_W-1:0] val, input int gap,
                             input bit typed, input t_result typed_res);
        t_result pred;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = list_apply(cmd, pos, val);
        pending_results = {pending_results, (typed ? typed_res : pred)};
        n_sent++;
        if (pred.status == ilid_pkg::ST_FULL) n_full++;
        if (pred.status == ilid_pkg::ST_RANGE) n_ignored++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected result: status %0d read %h length %0d",
                             o_status, o_read_value, o_list_length);
            end else begin
                got_res = pending_results.pop_front();
                n_checked++;
                if (o_status !== got_res.status || o_read_value !== got_res.read_value ||
                    o_list_length !== got_res.list_length) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("mismatch #%0d: status %0d/%0d read %h/%h length %0d/%0d",
                                 n_checked, got_res.status, o_status,
                                 got_res.read_value, o_read_value,
                                 got_res.list_length, o_list_length);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("[indexed_list_insert_delete] ERROR");
        $finish;
    end

    initial begin
        int                         gap;
        int                         pick;
        int                         len_now;
        bit                         growing;
        logic [2:0]                 cmd;
        logic [ilid_pkg::POS_W-1:0] pos;
        logic [ilid_pkg::VAL_W-1:0] val;
        t_row                       row;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        i_position = '0;
        i_value    = '0;
        list_len   = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_errors   = 0;
        n_full     = 0;
        n_ignored  = 0;
        peak_len   = 0;
        growing    = 1'b1;

        add_row(ilid_pkg::CMD_GET,      0, 0,             1, ilid_pkg::ST_RANGE, 0, 0);
        add_row(ilid_pkg::CMD_DEL_IDX,  0, 0,             1, ilid_pkg::ST_RANGE, 0, 0);
        add_row(ilid_pkg::CMD_ADD_IDX,  1, VAL_MAX,       1, ilid_pkg::ST_RANGE, 0, 0);
        add_row(CMD_RSVD_HI,  POS_MAX, VAL_MAX,           1, ilid_pkg::ST_RANGE, 0, 0);
        add_row(ilid_pkg::CMD_ADD_IDX,  0, VAL_MAX,       1, ilid_pkg::ST_DONE,  0, 1);
        add_row(ilid_pkg::CMD_GET,      0, 0,             1, ilid_pkg::ST_DONE,  VAL_MAX, 1);
        add_row(ilid_pkg::CMD_ADD_HEAD, 0, 0,             1, ilid_pkg::ST_DONE,  0, 2);
        add_row(ilid_pkg::CMD_ADD_TAIL, 0, 31'h5555_5555, 1, ilid_pkg::ST_DONE,  0, 3);
        add_row(ilid_pkg::CMD_ADD_IDX,  3, 31'h2AAA_AAAA, 1, ilid_pkg::ST_DONE,  0, 4);
        add_row(ilid_pkg::CMD_GET,      3, 0,             0, ilid_pkg::ST_DONE,  0, 0);
        add_row(ilid_pkg::CMD_GET,      4, 0,             1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(ilid_pkg::CMD_GET,      POS_MAX, 0,       1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(ilid_pkg::CMD_ADD_IDX,  5, 31'h1,         1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(ilid_pkg::CMD_ADD_IDX,  POS_MAX, VAL_MAX, 1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(ilid_pkg::CMD_DEL_IDX,  4, 0,             1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(ilid_pkg::CMD_DEL_IDX,  POS_MAX, 0,       1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(CMD_RSVD_LO,  0, 31'h0123_4567,           1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(CMD_RSVD_MID, 1, VAL_MAX,                 1, ilid_pkg::ST_RANGE, 0, 4);
        add_row(ilid_pkg::CMD_ADD_IDX,  2, 31'h1234_5678, 0, ilid_pkg::ST_DONE,  0, 0);
        add_row(ilid_pkg::CMD_GET,      2, 0,             0, ilid_pkg::ST_DONE,  0, 0);
        add_row(ilid_pkg::CMD_DEL_IDX,  0, 0,             0, ilid_pkg::ST_DONE,  0, 0);
        add_row(ilid_pkg::CMD_DEL_IDX,  3, 0,             0, ilid_pkg::ST_DONE,  0, 0);
        add_row(ilid_pkg::CMD_GET,      0, 0,             0, ilid_pkg::ST_DONE,  0, 0);
        add_row(ilid_pkg::CMD_ADD_IDX,  8'd128, 31'h7,    1, ilid_pkg::ST_RANGE, 0, 3);
        add_row(ilid_pkg::CMD_GET,      8'd64, 0,         1, ilid_pkg::ST_RANGE, 0, 3);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
            issue_cmd(row.cmd, row.pos, row.val, gap, row.typed, row.res);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // swing between filling the list up and draining it
            if (list_len == ilid_pkg::DEPTH && $urandom_range(0, 7) == 0) growing = 1'b0;
            if (list_len == 0) growing = 1'b1;
            if ($urandom_range(0, 99) == 0) growing = ~growing;

            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            else if (pick < 23)
                cmd = ilid_pkg::CMD_GET;
            else if (($urandom_range(0, 9) < 7) == growing)
                case ($urandom_range(0, 2))
                    0:       cmd = ilid_pkg::CMD_ADD_HEAD;
                    1:       cmd = ilid_pkg::CMD_ADD_TAIL;
                    default: cmd = ilid_pkg::CMD_ADD_IDX;
                endcase
            else
                cmd = ilid_pkg::CMD_DEL_IDX;

            len_now = list_len;
            case ($urandom_range(0, 9))
                0:       pos = ilid_pkg::POS_W'($urandom_range(0, 255));
                1:       pos = ilid_pkg::POS_W'(len_now);
                default: pos = ilid_pkg::POS_W'($urandom_range(0,
                                                 (len_now > 0) ? len_now - 1 : 0));
            endcase

            case ($urandom_range(0, 19))
                0:       val = VAL_MAX;
                1:       val = '0;
                default: val = ilid_pkg::VAL_W'($urandom);
            endcase

            gap = (n < N_RANDOM - QUIET_TAIL && $urandom_range(0, 5) == 0) ?
                  $urandom_range(1, 11) : 0;
            issue_cmd(cmd, pos, val, gap, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d transactions (%0d directed), %0d results checked, peak length %0d",
                 n_sent, dir_rows.size(), n_checked, peak_len);
        $display("%0d inserts refused on a full list, %0d commands ignored, %0d mismatches",
                 n_full, n_ignored, n_errors);
        if (n_errors == 0) begin
            $display("[indexed_list_insert_delete] OK");
        end else begin
            $display("[indexed_list_insert_delete] ERROR");
        end
        $finish;
    end

endmodule
